// ----- src/bech32_address_validator_core_assert.svh -----
// assertion macros used by the validator checker
`ifndef BECH32_ADDRESS_VALIDATOR_CORE_ASSERT_SVH
`define BECH32_ADDRESS_VALIDATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BAV_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BAV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bav_pkg.sv -----
// shared types, constants and functions of the bech32 address validator
package bav_pkg;

    localparam logic [6:0]  C_MIN_ADDR_LEN = 7'd14;
    localparam logic [6:0]  C_MAX_ADDR_LEN = 7'd90;
    localparam logic [6:0]  C_CNT_SAT      = 7'd127;
    localparam logic [5:0]  C_BYTE_SAT     = 6'd63;
    localparam logic [5:0]  C_PROG_MIN     = 6'd2;
    localparam logic [5:0]  C_PROG_MAX     = 6'd40;
    localparam logic [5:0]  C_PROG_V0_A    = 6'd20;
    localparam logic [5:0]  C_PROG_V0_B    = 6'd32;
    localparam logic [4:0]  C_VERSION_MAX  = 5'd16;
    localparam logic [2:0]  C_DELAY_DEPTH  = 3'd6;
    localparam logic [2:0]  C_MAX_PENDING  = 3'd3;
    localparam logic [7:0]  C_SEP_CHAR     = 8'h31;

    localparam logic [29:0] C_POLY_INIT    = 30'd1;
    localparam logic [29:0] C_BECH32M      = 30'h2bc830a3;
    // polymod state after the hrp expansion of "bc" has been fed from reset
    localparam logic [29:0] C_HRP_POLY     = 30'h2318043;

    localparam logic [29:0] C_GEN [5] = '{
        30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
    };

    typedef enum logic [3:0] {
        E_OK        = 4'd0,
        E_LENGTH    = 4'd1,
        E_MIXED     = 4'd2,
        E_PREFIX    = 4'd3,
        E_BAD_CHAR  = 4'd4,
        E_CHECKSUM  = 4'd5,
        E_VERSION   = 4'd6,
        E_PADDING   = 4'd7,
        E_PROG_LEN  = 4'd8
    } t_err;

    // one classified character handed from front to back
    typedef struct packed {
        logic [6:0] pos;
        logic       hrp_bad;
        logic       sym_bad;
        logic       lower;
        logic       upper;
        logic [4:0] sym;
        logic       last;
    } t_word;

    // one polymod step over a 5-bit symbol
    function automatic logic [29:0] poly_feed(input logic [29:0] s, input logic [4:0] v);
        logic [4:0]  top;
        logic [29:0] r;
        top = s[29:25];
        r   = {s[24:0], v};
        for (int k = 0; k < 5; k++) begin
            if (top[k]) begin
                r = r ^ C_GEN[k];
            end
        end
        return r;
    endfunction

    // expected prefix character at positions 0..2
    function automatic logic [7:0] hrp_char(input logic [1:0] p);
        logic [7:0] c;
        unique case (p)
            2'd0:    c = 8'h62;
            2'd1:    c = 8'h63;
            default: c = C_SEP_CHAR;
        endcase
        return c;
    endfunction

    // bech32 alphabet lookup: {valid, symbol}
    function automatic logic [5:0] sym_lookup(input logic [7:0] c);
        logic [5:0] r;
        unique case (c)
            8'h71: r = {1'b1, 5'd0};
            8'h70: r = {1'b1, 5'd1};
            8'h7a: r = {1'b1, 5'd2};
            8'h72: r = {1'b1, 5'd3};
            8'h79: r = {1'b1, 5'd4};
            8'h39: r = {1'b1, 5'd5};
            8'h78: r = {1'b1, 5'd6};
            8'h38: r = {1'b1, 5'd7};
            8'h67: r = {1'b1, 5'd8};
            8'h66: r = {1'b1, 5'd9};
            8'h32: r = {1'b1, 5'd10};
            8'h74: r = {1'b1, 5'd11};
            8'h76: r = {1'b1, 5'd12};
            8'h64: r = {1'b1, 5'd13};
            8'h77: r = {1'b1, 5'd14};
            8'h30: r = {1'b1, 5'd15};
            8'h73: r = {1'b1, 5'd16};
            8'h33: r = {1'b1, 5'd17};
            8'h6a: r = {1'b1, 5'd18};
            8'h6e: r = {1'b1, 5'd19};
            8'h35: r = {1'b1, 5'd20};
            8'h34: r = {1'b1, 5'd21};
            8'h6b: r = {1'b1, 5'd22};
            8'h68: r = {1'b1, 5'd23};
            8'h63: r = {1'b1, 5'd24};
            8'h65: r = {1'b1, 5'd25};
            8'h36: r = {1'b1, 5'd26};
            8'h6d: r = {1'b1, 5'd27};
            8'h75: r = {1'b1, 5'd28};
            8'h61: r = {1'b1, 5'd29};
            8'h37: r = {1'b1, 5'd30};
            8'h6c: r = {1'b1, 5'd31};
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/bav_in_if.sv -----
// character channel: one address byte per word
interface bav_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_char;

    modport source (output valid, output char_byte, output last_char, input ready);
    modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

// ----- src/bav_out_if.sv -----
// verdict channel: one result per address
interface bav_out_if;
    logic       valid;
    logic       ready;
    logic       address_valid;
    logic [3:0] error_code;
    logic [4:0] witness_version;
    logic [5:0] program_bytes;

    modport source (output valid, output address_valid, output error_code,
                    output witness_version, output program_bytes, input ready);
    modport sink   (input valid, input address_valid, input error_code,
                    input witness_version, input program_bytes, output ready);
endinterface

// ----- src/bav_front.sv -----
// front end: accepts characters, tracks position and classifies each one
module bav_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bav_in_if.sink        i_char,
    input  logic          i_full,
    output logic          o_push,
    output bav_pkg::t_word o_word
);
    import bav_pkg::*;

    logic [6:0] r_pos;
    logic [6:0] n_pos;
    logic [7:0] w_lc;
    logic [5:0] w_look;
    logic       w_is_upper;
    logic       w_is_lower;
    logic       w_in_hrp;

    assign i_char.ready = !i_full;
    assign o_push       = i_char.valid && !i_full;

    always_comb begin
        w_is_lower = (i_char.char_byte >= 8'h61) && (i_char.char_byte <= 8'h7a);
        w_is_upper = (i_char.char_byte >= 8'h41) && (i_char.char_byte <= 8'h5a);
        w_lc       = w_is_upper ? (i_char.char_byte + 8'h20) : i_char.char_byte;
        w_look     = sym_lookup(w_lc);
        w_in_hrp   = (r_pos < 7'd3);

        o_word.pos     = r_pos;
        o_word.lower   = w_is_lower;
        o_word.upper   = w_is_upper;
        o_word.last    = i_char.last_char;
        o_word.hrp_bad = w_in_hrp ? (w_lc != hrp_char(r_pos[1:0])) : (w_lc == C_SEP_CHAR);
        o_word.sym_bad = !w_in_hrp && (w_lc != C_SEP_CHAR) && !w_look[5];
        o_word.sym     = (!w_in_hrp && w_look[5]) ? w_look[4:0] : 5'd0;
    end

    always_comb begin
        n_pos = r_pos;
        if (o_push) begin
            if (i_char.last_char) begin
                n_pos = 7'd0;
            end else if (r_pos != C_CNT_SAT) begin
                n_pos = r_pos + 7'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 7'd0;
        end else begin
            r_pos <= n_pos;
        end
    end
endmodule

// ----- src/bav_fifo.sv -----
// two-entry queue of classified words between front and back
module bav_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bav_pkg::t_word i_word,
    output logic           o_full,
    input  logic           i_pop,
    output bav_pkg::t_word o_word,
    output logic           o_avail
);
    import bav_pkg::*;

    t_word      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_avail = (r_count != 2'd0);
    assign o_word  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end
endmodule

// ----- src/bav_back.sv -----
// back end: polymod, checksum delay line, bit converter and verdict register
module bav_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bav_pkg::t_word i_word,
    input  logic           i_avail,
    output logic           o_pop,
    bav_out_if.source      o_verdict
);
    import bav_pkg::*;

    logic [29:0]     r_poly,  n_poly;
    logic            r_lower, n_lower;
    logic            r_upper, n_upper;
    logic            r_pbad,  n_pbad;
    logic            r_cbad,  n_cbad;
    logic [4:0]      r_ver,   n_ver;
    logic [5:0][4:0] r_delay, n_delay;
    logic [2:0]      r_fill,  n_fill;
    logic [11:0]     r_acc,   n_acc;
    logic [3:0]      r_bits,  n_bits;
    logic [5:0]      r_bytes, n_bytes;

    logic            r_out_valid, n_out_valid;
    logic            r_out_ok,    n_out_ok;
    t_err            r_out_err,   n_out_err;
    logic [4:0]      r_out_ver,   n_out_ver;
    logic [5:0]      r_out_bytes, n_out_bytes;

    logic [3:0]      w_bits5;
    logic [6:0]      w_len;
    logic [11:0]     w_mask;
    logic [29:0]     w_target;
    t_err            w_err;

    assign o_verdict.valid           = r_out_valid;
    assign o_verdict.address_valid   = r_out_ok;
    assign o_verdict.error_code      = r_out_err;
    assign o_verdict.witness_version = r_out_ver;
    assign o_verdict.program_bytes   = r_out_bytes;

    always_comb begin
        o_pop = i_avail && (!i_word.last || !r_out_valid || o_verdict.ready);

        n_poly  = r_poly;
        n_lower = r_lower;
        n_upper = r_upper;
        n_pbad  = r_pbad;
        n_cbad  = r_cbad;
        n_ver   = r_ver;
        n_delay = r_delay;
        n_fill  = r_fill;
        n_acc   = r_acc;
        n_bits  = r_bits;
        n_bytes = r_bytes;

        n_out_valid = r_out_valid && !o_verdict.ready;
        n_out_ok    = r_out_ok;
        n_out_err   = r_out_err;
        n_out_ver   = r_out_ver;
        n_out_bytes = r_out_bytes;

        w_bits5  = r_bits + 4'd5;
        w_len    = 7'd0;
        w_mask   = 12'd0;
        w_target = C_POLY_INIT;
        w_err    = E_OK;

        if (o_pop) begin
            n_lower = r_lower | i_word.lower;
            n_upper = r_upper | i_word.upper;
            n_pbad  = r_pbad  | i_word.hrp_bad;
            n_cbad  = r_cbad  | i_word.sym_bad;

            if (i_word.pos == 7'd2) begin
                n_poly = C_HRP_POLY;
            end else if (i_word.pos > 7'd2) begin
                n_poly = poly_feed(r_poly, i_word.sym);
            end

            if (i_word.pos == 7'd3) begin
                n_ver = i_word.sym;
            end else if (i_word.pos > 7'd3) begin
                // the delay line holds back the six checksum symbols
                if (r_fill >= C_DELAY_DEPTH) begin
                    n_acc = {r_acc[6:0], r_delay[5]};
                    if (w_bits5 >= 4'd8) begin
                        n_bits = w_bits5 - 4'd8;
                        if (r_bytes != C_BYTE_SAT) begin
                            n_bytes = r_bytes + 6'd1;
                        end
                    end else begin
                        n_bits = w_bits5;
                    end
                end else begin
                    n_fill = r_fill + 3'd1;
                end
                n_delay = {r_delay[4:0], i_word.sym};
            end

            if (i_word.last) begin
                w_len    = (i_word.pos == C_CNT_SAT) ? C_CNT_SAT : (i_word.pos + 7'd1);
                w_mask   = (12'd1 << n_bits) - 12'd1;
                w_target = (n_ver == 5'd0) ? C_POLY_INIT : C_BECH32M;
                priority if (w_len < C_MIN_ADDR_LEN || w_len > C_MAX_ADDR_LEN) begin
                    w_err = E_LENGTH;
                end else if (n_lower && n_upper) begin
                    w_err = E_MIXED;
                end else if (n_pbad) begin
                    w_err = E_PREFIX;
                end else if (n_cbad) begin
                    w_err = E_BAD_CHAR;
                end else if (n_poly != w_target) begin
                    w_err = E_CHECKSUM;
                end else if (n_ver > C_VERSION_MAX) begin
                    w_err = E_VERSION;
                end else if (n_bits >= 4'd5 || (n_acc & w_mask) != 12'd0) begin
                    w_err = E_PADDING;
                end else if (n_bytes < C_PROG_MIN || n_bytes > C_PROG_MAX ||
                             (n_ver == 5'd0 && n_bytes != C_PROG_V0_A &&
                              n_bytes != C_PROG_V0_B)) begin
                    w_err = E_PROG_LEN;
                end else begin
                    w_err = E_OK;
                end

                n_out_valid = 1'b1;
                n_out_ok    = (w_err == E_OK);
                n_out_err   = w_err;
                n_out_ver   = n_ver;
                n_out_bytes = n_bytes;

                // back to the reset state for the next address
                n_poly  = C_POLY_INIT;
                n_lower = 1'b0;
                n_upper = 1'b0;
                n_pbad  = 1'b0;
                n_cbad  = 1'b0;
                n_ver   = 5'd0;
                n_delay = '0;
                n_fill  = 3'd0;
                n_acc   = 12'd0;
                n_bits  = 4'd0;
                n_bytes = 6'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly      <= C_POLY_INIT;
            r_lower     <= 1'b0;
            r_upper     <= 1'b0;
            r_pbad      <= 1'b0;
            r_cbad      <= 1'b0;
            r_ver       <= 5'd0;
            r_delay     <= '0;
            r_fill      <= 3'd0;
            r_acc       <= 12'd0;
            r_bits      <= 4'd0;
            r_bytes     <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_poly      <= n_poly;
            r_lower     <= n_lower;
            r_upper     <= n_upper;
            r_pbad      <= n_pbad;
            r_cbad      <= n_cbad;
            r_ver       <= n_ver;
            r_delay     <= n_delay;
            r_fill      <= n_fill;
            r_acc       <= n_acc;
            r_bits      <= n_bits;
            r_bytes     <= n_bytes;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ok    <= n_out_ok;
        r_out_err   <= n_out_err;
        r_out_ver   <= n_out_ver;
        r_out_bytes <= n_out_bytes;
    end
endmodule

// ----- src/bech32_address_validator_core.sv -----
// top level of the streaming bech32 / bech32m segwit address validator
//
//  channel     dir  word                                   handshake
//  i_char      in   char_byte[7:0], last_char              valid / ready
//  o_verdict   out  address_valid, error_code[3:0],        valid / ready
//                   witness_version[4:0], program_bytes[5:0]
//
// one character per cycle sustained while the queue has room; the polymod step in the back end sets the pace
// a verdict is registered: the last character goes through the queue, then the back end loads the verdict register,
// once the words still queued ahead of it have been handled
// synchronous active-low reset empties the queue and the verdict register, no clearing pass
// a stalled verdict holds; the front keeps taking characters until the two-word queue fills
module bech32_address_validator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bav_in_if.sink     i_char,
    bav_out_if.source  o_verdict
);
    import bav_pkg::*;

    // front to queue
    t_word w_push_word;
    logic  w_push;
    logic  w_full;

    // queue to back
    t_word w_pop_word;
    logic  w_pop;
    logic  w_avail;

    // position tracking and per-character classification
    bav_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_word  (w_push_word)
    );

    // decouples the front from a stalled verdict
    bav_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_push_word),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_word  (w_pop_word),
        .o_avail (w_avail)
    );

    // checksum, conversion and final verdict
    bav_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_word    (w_pop_word),
        .i_avail   (w_avail),
        .o_pop     (w_pop),
        .o_verdict (o_verdict)
    );
endmodule

// ----- src/bav_checker.sv -----
// port-level checker for the validator, bound to the top level
`include "bech32_address_validator_core_assert.svh"

module bav_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_last,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_ok,
    input logic [3:0] i_out_err,
    input logic [4:0] i_out_ver,
    input logic [5:0] i_out_bytes
);
    import bav_pkg::*;

    // addresses whose last character went in but whose verdict is not yet taken
    logic [2:0] r_pend;
    logic [2:0] n_pend;
    logic       w_in_last;
    logic       w_out_take;

    assign w_in_last  = i_in_valid && i_in_ready && i_in_last;
    assign w_out_take = i_out_valid && i_out_ready;

    always_comb begin
        n_pend = r_pend;
        if (w_in_last && !w_out_take) begin
            n_pend = r_pend + 3'd1;
        end else if (w_out_take && !w_in_last) begin
            n_pend = r_pend - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 3'd0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `BAV_ASSERT_NEXT(a_verdict_held, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_ok) && $stable(i_out_err) && $stable(i_out_ver) &&
        $stable(i_out_bytes), "stalled verdict changed")
    `BAV_ASSERT_NOW(a_verdict_has_address, i_clk, i_rst_n, i_out_valid, r_pend != 3'd0,
        "verdict without a finished address")
    `BAV_ASSERT_NOW(a_pending_bound, i_clk, i_rst_n, 1'b1, r_pend <= C_MAX_PENDING,
        "more addresses in flight than storage holds")
    `BAV_ASSERT_NOW(a_full_stalls, i_clk, i_rst_n, r_pend == C_MAX_PENDING, !i_in_ready,
        "input taken with queue and verdict full")
    `BAV_ASSERT_NOW(a_code_consistent, i_clk, i_rst_n, i_out_valid,
        (i_out_ok == (i_out_err == E_OK)) && (i_out_err <= E_PROG_LEN),
        "verdict flag and error code disagree")
endmodule

bind bech32_address_validator_core bav_checker u_bav_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_char.valid),
    .i_in_ready  (i_char.ready),
    .i_in_last   (i_char.last_char),
    .i_out_valid (o_verdict.valid),
    .i_out_ready (o_verdict.ready),
    .i_out_ok    (o_verdict.address_valid),
    .i_out_err   (o_verdict.error_code),
    .i_out_ver   (o_verdict.witness_version),
    .i_out_bytes (o_verdict.program_bytes)
);
